// File: rtl/assert_macros.svh
// Assertion macros used by the RTL file crc32_word_block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another one in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Check that a condition implies another one in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// File: rtl/crcw_pkg.sv
`default_nettype none

package crcw_pkg;

  localparam int WORD_W = 32;
  localparam int CNT_W = $clog2(WORD_W);
  localparam int CFG_IDX_W = 4;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [WORD_W-1:0] cols_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Register indexes of the configuration port
  localparam cfg_idx_t REG_POLY = cfg_idx_t'(0);
  localparam cfg_idx_t REG_START = cfg_idx_t'(1);

  localparam word_t ALL_ONES = 32'hFFFF_FFFF;
  localparam word_t DEFAULT_POLY = 32'h04C1_1DB7;
  localparam cnt_t CNT_LAST = cnt_t'(WORD_W - 1);

  // Reverse the bit order of a word
  function automatic word_t reflect_word(word_t v);
    word_t r;
    for (int k = 0; k < WORD_W; k++) begin
      r[k] = v[WORD_W-1-k];
    end
    return r;
  endfunction

  // Multiply by x modulo the generator
  function automatic word_t col_step(word_t t, word_t p);
    word_t r;
    r = {t[WORD_W-2:0], 1'b0} ^ (t[WORD_W-1] ? p : '0);
    return r;
  endfunction

  // Apply the 32-step fold matrix to a word: XOR of the selected columns
  function automatic word_t mat_apply(cols_t c, word_t x);
    word_t acc;
    acc = '0;
    for (int j = 0; j < WORD_W; j++) begin
      acc = acc ^ (x[j] ? c[j] : '0);
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

// File: rtl/crcw_table.sv
`default_nettype none

// Holds the polynomial and the columns x^(32+j) mod G of the fold matrix.
// Rebuilds the columns one per cycle after reset and after each write.
module crcw_table (
  input  wire                logic           clk,
  input  wire                logic           rst_n,
  input  wire                logic           poly_we,
  input  wire                crcw_pkg::word_t poly_wdata,
  output logic               busy,
  output crcw_pkg::cols_t    cols
);

  crcw_pkg::word_t poly_r;
  crcw_pkg::word_t tk_r;
  crcw_pkg::cnt_t  cnt_r;
  logic            busy_r;
  crcw_pkg::cols_t cols_r;

  // Hold the polynomial and sequence the column sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r <= crcw_pkg::DEFAULT_POLY;
      tk_r   <= crcw_pkg::DEFAULT_POLY;
      cnt_r  <= '0;
      busy_r <= 1'b1;
    end else if (poly_we) begin
      poly_r <= poly_wdata;
      tk_r   <= poly_wdata;
      cnt_r  <= '0;
      busy_r <= 1'b1;
    end else if (busy_r) begin
      tk_r  <= crcw_pkg::col_step(tk_r, poly_r);
      cnt_r <= cnt_r + crcw_pkg::cnt_t'(1);
      if (cnt_r == crcw_pkg::CNT_LAST) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Store one column per sweep cycle
  always_ff @(posedge clk) begin
    if (busy_r) begin
      cols_r[cnt_r] <= tk_r;
    end
  end

  assign busy = busy_r;
  assign cols = cols_r;

endmodule

`default_nettype wire

// File: rtl/crc32_word_block.sv
// Word-wise reflected CRC-32 over blocks of 32-bit words.
// Input channel: in_word, in_last with in_valid / in_stall; a word transfers
// on a clock edge with in_valid high and in_stall low. The word marked last
// closes the block. Result channel: out_crc_out with out_valid / out_stall,
// one result per block, reflected CRC register XOR all ones.
// Configuration: cfg_we, cfg_index, cfg_wdata; index 0 is the polynomial,
// index 1 the start value (also loaded into the CRC register at once).
// The result of a last word is loaded into the output register when that
// word leaves the input register. One word per cycle while in_stall is low;
// the register-to-register path is a 32-column XOR fold matrix applied to
// (CRC ^ reflected word). After reset and after every polynomial write the
// 32 matrix columns are rebuilt one per cycle with in_stall high; reset also
// loads the default polynomial 0x04C11DB7 and start value 0xFFFFFFFF.
// When the receiver stalls, the result is held in the output register and
// words not marked last keep flowing; a last word waits in the input
// register until the output register frees up.
`default_nettype none

`include "assert_macros.svh"

module crc32_word_block (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [31:0]            in_word,
  input  wire logic                   in_last,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [31:0]                 out_crc_out,
  input  wire logic                   cfg_we,
  input  wire crcw_pkg::cfg_idx_t     cfg_index,
  input  wire logic [31:0]            cfg_wdata
);

  logic            s1_vld_r;
  crcw_pkg::word_t word_r;
  logic            last_r;
  crcw_pkg::word_t crc_r;
  crcw_pkg::word_t start_r;
  logic            out_vld_r;
  crcw_pkg::word_t out_crc_r;

  logic            tbl_busy;
  crcw_pkg::cols_t tbl_cols;
  logic            poly_we;
  logic            start_we;
  logic            out_free;
  logic            s1_go;
  logic            in_xfer;
  crcw_pkg::word_t fold_nxt;

  assign poly_we  = cfg_we && (cfg_index == crcw_pkg::REG_POLY);
  assign start_we = cfg_we && (cfg_index == crcw_pkg::REG_START);

  crcw_table u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .poly_we    (poly_we),
    .poly_wdata (cfg_wdata),
    .busy       (tbl_busy),
    .cols       (tbl_cols)
  );

  // Advance the input register when its word can be folded
  assign out_free = !out_vld_r || !out_stall;
  assign s1_go    = s1_vld_r && (!last_r || out_free);
  assign in_stall = tbl_busy || (s1_vld_r && !s1_go);
  assign in_xfer  = in_valid && !in_stall;

  // Fold one word through the precomputed matrix
  assign fold_nxt = crcw_pkg::mat_apply(tbl_cols, crc_r ^ crcw_pkg::reflect_word(word_r));

  // Hold the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_xfer) begin
      s1_vld_r <= 1'b1;
    end else if (s1_go) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      word_r <= in_word;
      last_r <= in_last;
    end
  end

  // Update the running CRC and the start value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= crcw_pkg::ALL_ONES;
      crc_r   <= crcw_pkg::ALL_ONES;
    end else if (start_we) begin
      start_r <= cfg_wdata;
      crc_r   <= cfg_wdata;
    end else if (s1_go) begin
      crc_r <= last_r ? start_r : fold_nxt;
    end
  end

  // Load the result register on a last word, drop it once transferred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_go && last_r) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && last_r) begin
      out_crc_r <= crcw_pkg::reflect_word(fold_nxt) ^ crcw_pkg::ALL_ONES;
    end
  end

  assign out_valid   = out_vld_r;
  assign out_crc_out = out_crc_r;

  `ASSERT_SAME(a_busy_stalls, clk, rst_n, tbl_busy, in_stall)
  `ASSERT_NEXT(a_last_gives_result, clk, rst_n, s1_go && last_r, out_vld_r)
  `ASSERT_NEXT(a_plain_word_no_result, clk, rst_n, s1_go && !last_r && out_free, !out_vld_r)
  `ASSERT_SAME(a_last_waits_for_room, clk, rst_n, s1_vld_r && last_r && !out_free, in_stall)

endmodule

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_WORDS = 125;

  // Predict finished CRCs and match them against the result channel
  class crc_scoreboard;
    crcw_pkg::word_t gen_poly;
    crcw_pkg::word_t seed_val;
    crcw_pkg::word_t crc_acc;
    crcw_pkg::word_t pending_crcs[$];
    int errors;

    function new();
      gen_poly = crcw_pkg::DEFAULT_POLY;
      seed_val = crcw_pkg::ALL_ONES;
      crc_acc = crcw_pkg::ALL_ONES;
      errors = 0;
    endfunction

    function crcw_pkg::word_t flip_bits(crcw_pkg::word_t v);
      crcw_pkg::word_t r;
      for (int k = 0; k < crcw_pkg::WORD_W; k++) begin
        r[k] = v[crcw_pkg::WORD_W-1-k];
      end
      return r;
    endfunction

    // Shift the word in LSB first, one polynomial division step per bit
    function crcw_pkg::word_t shift_in_word(crcw_pkg::word_t acc, crcw_pkg::word_t w);
      logic top;
      for (int k = 0; k < crcw_pkg::WORD_W; k++) begin
        top = acc[crcw_pkg::WORD_W-1];
        acc = {acc[crcw_pkg::WORD_W-2:0], 1'b0};
        if (top ^ w[k]) begin
          acc = acc ^ gen_poly;
        end
      end
      return acc;
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Track register writes; a new start value drops any open block
    function void write_reg(crcw_pkg::cfg_idx_t idx, crcw_pkg::word_t v);
      if (idx == crcw_pkg::REG_POLY) begin
        gen_poly = v;
      end else if (idx == crcw_pkg::REG_START) begin
        seed_val = v;
        crc_acc = v;
      end
    endfunction

    // Fold an accepted word; queue the finished CRC on the last word
    function void note_word(crcw_pkg::word_t w, logic last);
      crc_acc = shift_in_word(crc_acc, w);
      if (last) begin
        pending_crcs.push_back(flip_bits(crc_acc) ^ crcw_pkg::ALL_ONES);
        crc_acc = seed_val;
      end
    endfunction

    task check_crc(crcw_pkg::word_t got);
      crcw_pkg::word_t want;
      if (pending_crcs.size() == 0) begin
        report($sformatf("result %h with no block closed", got));
      end else begin
        want = pending_crcs.pop_front();
        if (got !== want) begin
          report($sformatf("crc_out %h, predicted %h", got, want));
        end
      end
    endtask

    function int outstanding();
      return pending_crcs.size();
    endfunction

    task check_drained();
      while (pending_crcs.size() > 0) begin
        report($sformatf("predicted crc %h never came", pending_crcs.pop_front()));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] in_word = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] out_crc_out;
  logic cfg_we = 1'b0;
  crcw_pkg::cfg_idx_t cfg_index = crcw_pkg::REG_POLY;
  logic [31:0] cfg_wdata = '0;

  crc_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_request = 1'b0;
  int idle_cycles = 0;

  crc32_word_block dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .in_last(in_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_crc_out(out_crc_out),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Sample both channels at the rising edge; watch for a hung block
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_word(in_word, in_last);
      end
      if (out_valid && !out_stall) begin
        sb.check_crc(out_crc_out);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[%0t] no transfer for %0d cycles", $realtime, IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Receiver: random stall, or a long hold-off on request
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic crcw_pkg::word_t rand_word();
    case ($urandom_range(7))
      0: return '0;
      1: return crcw_pkg::ALL_ONES;
      2: return crcw_pkg::word_t'(1) << $urandom_range(crcw_pkg::WORD_W - 1);
      3: return ~(crcw_pkg::word_t'(1) << $urandom_range(crcw_pkg::WORD_W - 1));
      default: return crcw_pkg::word_t'($urandom);
    endcase
  endfunction

  // Offer one word from a falling edge until it transfers
  task automatic send_word(input crcw_pkg::word_t w, input logic last);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_word <= crcw_pkg::word_t'($urandom);
      in_last <= 1'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    in_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_block(input int n, input bit close);
    for (int i = 0; i < n; i++) begin
      send_word(rand_word(), close && (i == n - 1));
    end
  endtask

  // Pause the sender until every result is out, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.outstanding() > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(input crcw_pkg::cfg_idx_t idx, input crcw_pkg::word_t v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_bad_index();
    write_cfg(crcw_pkg::cfg_idx_t'($urandom_range(int'(crcw_pkg::REG_START) + 1,
                                                  (1 << crcw_pkg::CFG_IDX_W) - 1)),
              crcw_pkg::word_t'($urandom));
  endtask

  task automatic run_blocks(input int words);
    int sent;
    int n;
    sent = 0;
    while (sent < words) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
      send_block(n, 1'b1);
      sent += n;
    end
  endtask

  initial begin : stimulus
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: default settings, extreme words, multi-word blocks
    send_word('0, 1'b1);
    send_word(crcw_pkg::ALL_ONES, 1'b1);
    send_word(32'h1234_5678, 1'b0);
    send_word(32'h9ABC_DEF0, 1'b1);
    send_word(32'h0000_0001, 1'b0);
    send_word(32'h8000_0000, 1'b0);
    send_word(crcw_pkg::ALL_ONES, 1'b1);

    // New polynomial in the middle of a block keeps the running CRC
    send_word(32'hA5A5_5A5A, 1'b0);
    drain();
    write_cfg(crcw_pkg::REG_POLY, 32'h1EDC_6F41);
    send_word(32'hDEAD_BEEF, 1'b1);

    // New start value in the middle of a block drops it
    send_word(32'h0F0F_F0F0, 1'b0);
    send_word(32'h3C3C_C3C3, 1'b0);
    drain();
    write_cfg(crcw_pkg::REG_START, '0);
    send_word(32'h7777_0000, 1'b1);

    // Write past the register list: nothing changes
    drain();
    write_bad_index();
    send_word(32'h0000_FFFF, 1'b0);
    send_word(32'hFFFF_0000, 1'b1);

    // Back to defaults for the first random phase
    drain();
    write_cfg(crcw_pkg::REG_POLY, crcw_pkg::DEFAULT_POLY);
    write_cfg(crcw_pkg::REG_START, crcw_pkg::ALL_ONES);

    // Phase 0: no idling, then a long receiver hold-off while words keep coming
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_blocks(PHASE_WORDS - 30);
    hold_request = 1'b1;
    run_blocks(30);
    send_block(2, 1'b0);
    drain();

    // Phase 1: idle sender, new polynomial carried into an open block
    write_cfg(crcw_pkg::REG_POLY, crcw_pkg::word_t'($urandom));
    send_idle_pct = 63;
    run_blocks(PHASE_WORDS);
    send_block(3, 1'b0);
    drain();

    // Phase 2: stalling receiver, all-ones polynomial, zero start value
    write_cfg(crcw_pkg::REG_POLY, crcw_pkg::ALL_ONES);
    write_cfg(crcw_pkg::REG_START, '0);
    send_idle_pct = 0;
    recv_stall_pct = 63;
    run_blocks(PHASE_WORDS);
    send_block(1, 1'b0);
    drain();

    // Phase 3: both sides idle, zero polynomial, random start value
    write_cfg(crcw_pkg::REG_POLY, '0);
    write_cfg(crcw_pkg::REG_START, crcw_pkg::word_t'($urandom));
    write_bad_index();
    send_idle_pct = 24;
    recv_stall_pct = 24;
    run_blocks(PHASE_WORDS / 2);
    drain();
    write_cfg(crcw_pkg::REG_POLY, crcw_pkg::word_t'($urandom) | crcw_pkg::word_t'(1));
    write_cfg(crcw_pkg::REG_START, crcw_pkg::ALL_ONES);
    run_blocks(PHASE_WORDS / 2);

    drain();
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
